/* rtl/core/dmcl_pkg.sv */
`timescale 1ns / 1ps
// dmcl_pkg: constants, register codes and controller/datapath interface types
// for the direct-mapped cache lookup. No dependencies.
package dmcl_pkg;

	localparam int CFG_W      = 4;
	localparam int COUNT_W    = 32;
	localparam int OFFSET_MIN = 4;
	localparam int OFFSET_MAX = 8;
	localparam int SHAMT_W    = 5;
	localparam int M_DATA_W   = 72;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// register select is paddr[2]
	localparam logic REG_OFFSET_BITS = 1'b0;
	localparam logic REG_INDEX_BITS  = 1'b1;

	typedef struct packed {
		logic clr;      // clearing sweep: write one line invalid
		logic load;     // capture input beat
		logic lookup;   // read tag RAM at computed line
		logic resolve;  // compare, update line and counters, load result
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last; // sweep is at the last line
	} ctrl_sts_t;

endpackage

/* rtl/core/dmcl_ram.sv */
`timescale 1ns / 1ps
// dmcl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmcl_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/dmcl_ctrl.sv */
`timescale 1ns / 1ps
// dmcl_ctrl: sequencer for the cache lookup (clear sweep, accept, read, resolve)
// and the output valid flag. Depends on dmcl_pkg.
module dmcl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  dmcl_pkg::ctrl_sts_t sts,
	output dmcl_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_RESOLVE
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;

	always_comb begin
		cmd         = '0;
		cmd.clr     = (state_q == ST_CLEAR);
		cmd.load    = (state_q == ST_IDLE) && s_tvalid;
		cmd.lookup  = (state_q == ST_LOOKUP);
		cmd.resolve = (state_q == ST_RESOLVE) && (!m_tvalid_q || m_tready);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.resolve) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					if (cmd.resolve) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

/* rtl/core/dmcl_dp.sv */
`timescale 1ns / 1ps
// dmcl_dp: address split, tag RAM with valid bit, hit compare, counters and
// result register. Depends on dmcl_pkg and dmcl_ram.
module dmcl_dp #(
	parameter int MAX_LINES  = 1024,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dmcl_pkg::ctrl_cmd_t            cmd,
	output dmcl_pkg::ctrl_sts_t            sts,
	input  logic [dmcl_pkg::CFG_W-1:0]     offset_bits,
	input  logic [dmcl_pkg::CFG_W-1:0]     index_bits,
	input  logic [ADDR_WIDTH-1:0]          address,
	output logic                           hit,
	output logic [dmcl_pkg::COUNT_W-1:0]   hit_count,
	output logic [dmcl_pkg::COUNT_W-1:0]   access_count
);

	localparam int LINE_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int INDEX_CAP = $clog2(MAX_LINES + 1) - 1;
	localparam int TAG_W     = ADDR_WIDTH - dmcl_pkg::OFFSET_MIN;
	localparam int ENTRY_W   = TAG_W + 1;

	logic [ADDR_WIDTH-1:0]           addr_q;
	logic [LINE_W-1:0]               line_q;
	logic [LINE_W-1:0]               clr_q;
	logic [dmcl_pkg::COUNT_W-1:0]    hits_q;
	logic [dmcl_pkg::COUNT_W-1:0]    acc_q;
	logic                            out_hit_q;
	logic [dmcl_pkg::COUNT_W-1:0]    out_hits_q;
	logic [dmcl_pkg::COUNT_W-1:0]    out_acc_q;

	logic [dmcl_pkg::CFG_W-1:0]      off_eff;
	logic [dmcl_pkg::SHAMT_W-1:0]    ib_eff;
	logic [dmcl_pkg::SHAMT_W-1:0]    tag_shamt;
	logic [LINE_W-1:0]               line_mask;
	logic [LINE_W-1:0]               line_c;
	logic [TAG_W-1:0]                tag_c;
	logic                            hit_c;
	logic                            ram_we;
	logic [LINE_W-1:0]               ram_waddr;
	logic [ENTRY_W-1:0]              ram_wdata;
	logic [ENTRY_W-1:0]              ram_rdata;

	always_comb begin
		if (offset_bits < dmcl_pkg::CFG_W'(dmcl_pkg::OFFSET_MIN)) begin
			off_eff = dmcl_pkg::CFG_W'(dmcl_pkg::OFFSET_MIN);
		end else if (offset_bits > dmcl_pkg::CFG_W'(dmcl_pkg::OFFSET_MAX)) begin
			off_eff = dmcl_pkg::CFG_W'(dmcl_pkg::OFFSET_MAX);
		end else begin
			off_eff = offset_bits;
		end
		if ({1'b0, index_bits} > dmcl_pkg::SHAMT_W'(INDEX_CAP)) begin
			ib_eff = dmcl_pkg::SHAMT_W'(INDEX_CAP);
		end else begin
			ib_eff = {1'b0, index_bits};
		end
		tag_shamt = {1'b0, off_eff} + ib_eff;
		line_mask = ~({LINE_W{1'b1}} << ib_eff);
		line_c    = LINE_W'(addr_q >> off_eff) & line_mask;
		tag_c     = TAG_W'(addr_q >> tag_shamt);
		hit_c     = ram_rdata[TAG_W] && (ram_rdata[TAG_W-1:0] == tag_c);
	end

	always_comb begin
		ram_we    = cmd.clr || (cmd.resolve && !hit_c);
		ram_waddr = cmd.clr ? clr_q : line_q;
		ram_wdata = cmd.clr ? '0 : {1'b1, tag_c};
	end

	assign sts.clr_last = (clr_q == LINE_W'(MAX_LINES - 1));

	dmcl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_LINES)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.lookup),
		.raddr(line_c),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= address;
		end
		if (cmd.lookup) begin
			line_q <= line_c;
		end
		if (cmd.resolve) begin
			out_hit_q  <= hit_c;
			out_hits_q <= hit_c ? hits_q + 1'b1 : hits_q;
			out_acc_q  <= acc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			hits_q <= '0;
			acc_q  <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.resolve) begin
				acc_q <= acc_q + 1'b1;
				if (hit_c) begin
					hits_q <= hits_q + 1'b1;
				end
			end
		end
	end

	assign hit          = out_hit_q;
	assign hit_count    = out_hits_q;
	assign access_count = out_acc_q;

endmodule

/* rtl/core/direct_mapped_cache_lookup.sv */
`timescale 1ns / 1ps
// Direct-mapped cache tag store: top level with APB config registers,
// controller and datapath. Depends on dmcl_pkg, dmcl_ctrl, dmcl_dp, dmcl_ram.
//
// Each input beat is one byte address; each output beat gives the hit flag
// and the running hit and access counts (both wrap at 2^32). offset_bits
// (APB 0x0, clamped to 4..8) and index_bits (APB 0x4, capped at
// log2(MAX_LINES)) set the offset/line/tag split; stored lines survive a
// change of split. Lookups are handled one at a time in three steps
// (accept, tag RAM read, compare and write back), as the single tag RAM has
// a registered read; the compare waits while an older result is not taken.
// A finished result waits in an output register while the next address is
// accepted. After reset the block sweeps all MAX_LINES tag RAM lines, one
// line per cycle, before accepting addresses; config writes go in meanwhile.
module direct_mapped_cache_lookup #(
	parameter int MAX_LINES  = 1024,
	parameter int ADDR_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side: tdata = address
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((ADDR_WIDTH + 7) / 8) * 8-1:0] s_tdata,
	// master side: tdata = hit[0], hit_count[32:1], access_count[64:33], zero fill
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [dmcl_pkg::M_DATA_W-1:0]         m_tdata,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [dmcl_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [dmcl_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [dmcl_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready
);

	logic [dmcl_pkg::CFG_W-1:0]    offset_bits_q;
	logic [dmcl_pkg::CFG_W-1:0]    index_bits_q;
	dmcl_pkg::ctrl_cmd_t           cmd;
	dmcl_pkg::ctrl_sts_t           sts;
	logic                          hit;
	logic [dmcl_pkg::COUNT_W-1:0]  hit_count;
	logic [dmcl_pkg::COUNT_W-1:0]  access_count;
	logic                          cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= dmcl_pkg::CFG_W'(4);
			index_bits_q  <= dmcl_pkg::CFG_W'(10);
		end else if (cfg_we) begin
			case (paddr[2])
				dmcl_pkg::REG_OFFSET_BITS: offset_bits_q <= pwdata[dmcl_pkg::CFG_W-1:0];
				dmcl_pkg::REG_INDEX_BITS:  index_bits_q  <= pwdata[dmcl_pkg::CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			dmcl_pkg::REG_OFFSET_BITS:
				prdata = {{(dmcl_pkg::APB_DATA_W - dmcl_pkg::CFG_W){1'b0}}, offset_bits_q};
			dmcl_pkg::REG_INDEX_BITS:
				prdata = {{(dmcl_pkg::APB_DATA_W - dmcl_pkg::CFG_W){1'b0}}, index_bits_q};
			default:
				prdata = '0;
		endcase
	end

	dmcl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dmcl_dp #(
		.MAX_LINES (MAX_LINES),
		.ADDR_WIDTH(ADDR_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.offset_bits (offset_bits_q),
		.index_bits  (index_bits_q),
		.address     (s_tdata[ADDR_WIDTH-1:0]),
		.hit         (hit),
		.hit_count   (hit_count),
		.access_count(access_count)
	);

	assign m_tdata = {
		{(dmcl_pkg::M_DATA_W - 2 * dmcl_pkg::COUNT_W - 1){1'b0}},
		access_count,
		hit_count,
		hit
	};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for direct_mapped_cache_lookup. A directed table, then
// random address streams under several offset/index splits and handshake pacings.
// Depends on dmcl_pkg and the RTL of the block.
module tb_top;

	localparam int LINES      = 1024;
	localparam int LINE_BITS  = $clog2(LINES);
	localparam int QUIET_MAX  = 4000;
	localparam int SEG_ITEMS  = 70;
	localparam int SEGMENTS   = 5;

	localparam logic [dmcl_pkg::APB_ADDR_W-1:0] ADDR_OFFSET_BITS =
		{dmcl_pkg::REG_OFFSET_BITS, 2'b00};
	localparam logic [dmcl_pkg::APB_ADDR_W-1:0] ADDR_INDEX_BITS  =
		{dmcl_pkg::REG_INDEX_BITS, 2'b00};

	typedef struct packed {
		logic        hit;
		logic [31:0] hit_count;
		logic [31:0] access_count;
	} lookup_result_t;

	typedef enum logic {ROW_CFG, ROW_ADDR} row_kind_t;

	typedef struct {
		row_kind_t      kind;
		logic           reg_sel;
		logic [31:0]    data;
		logic           typed;
		lookup_result_t res;
	} row_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [31:0]                     s_tdata   = '0;   // address
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [dmcl_pkg::M_DATA_W-1:0]   m_tdata;  // hit, hit_count, access_count, zero fill
	logic                            psel      = 1'b0;
	logic                            penable   = 1'b0;
	logic                            pwrite    = 1'b0;
	logic [dmcl_pkg::APB_ADDR_W-1:0] paddr     = '0;
	logic [dmcl_pkg::APB_DATA_W-1:0] pwdata    = '0;
	logic [dmcl_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	direct_mapped_cache_lookup u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic        pred_valid [LINES];
	logic [31:0] pred_tag   [LINES];
	logic [31:0] pred_hits;
	logic [31:0] pred_accesses;
	int unsigned eff_off;
	int unsigned eff_ib;

	lookup_result_t expected_q [$];
	int             mismatches   = 0;
	int             gap_pct      = 0;
	int             stall_pct    = 0;
	int             quiet_cycles = 0;
	int             splits_used  = 0;
	logic [31:0]    addr_pool [16];

	row_t dir_rows [23] = '{
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 32'd1}},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b1, '{1'b1, 32'd1, 32'd2}},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h0000_000F, 1'b1, '{1'b1, 32'd2, 32'd3}},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd2, 32'd4}},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'hFFFF_FFF0, 1'b1, '{1'b1, 32'd3, 32'd5}},
		// same line, other tag: evicts line 0
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h0000_4000, 1'b1, '{1'b0, 32'd3, 32'd6}},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b1, '{1'b0, 32'd3, 32'd7}},
		// offset below range acts as 4
		'{ROW_CFG,  dmcl_pkg::REG_OFFSET_BITS, 32'h0000_0000, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h0000_0010, 1'b0, '0},
		// offset above range acts as 8, single line
		'{ROW_CFG,  dmcl_pkg::REG_OFFSET_BITS, 32'h0000_000F, 1'b0, '0},
		'{ROW_CFG,  dmcl_pkg::REG_INDEX_BITS,  32'h0000_0000, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h1234_5678, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h1234_56FF, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h1234_5700, 1'b0, '0},
		// index above cap
		'{ROW_CFG,  dmcl_pkg::REG_INDEX_BITS,  32'h0000_000F, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'hFFFF_FF00, 1'b0, '0},
		// upper write data bits are dropped
		'{ROW_CFG,  dmcl_pkg::REG_OFFSET_BITS, 32'hFFFF_FFF8, 1'b0, '0},
		'{ROW_CFG,  dmcl_pkg::REG_OFFSET_BITS, 32'h0000_0004, 1'b0, '0},
		'{ROW_CFG,  dmcl_pkg::REG_INDEX_BITS,  32'h0000_000A, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'hAAAA_AAAA, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'h5555_5555, 1'b0, '0},
		'{ROW_ADDR, dmcl_pkg::REG_OFFSET_BITS, 32'hAAAA_AAAA, 1'b0, '0}
	};

	function automatic lookup_result_t cache_predict(input logic [31:0] a);
		int unsigned    line;
		logic [31:0]    tag;
		lookup_result_t r;
		line = (a >> eff_off) & ((32'd1 << eff_ib) - 1);
		tag  = a >> (eff_off + eff_ib);
		r.hit = pred_valid[line] && pred_tag[line] == tag;
		if (r.hit) begin
			pred_hits = pred_hits + 1;
		end else begin
			pred_valid[line] = 1'b1;
			pred_tag[line]   = tag;
		end
		pred_accesses  = pred_accesses + 1;
		r.hit_count    = pred_hits;
		r.access_count = pred_accesses;
		return r;
	endfunction

	task automatic apb_access(input logic wr, input logic [dmcl_pkg::APB_ADDR_W-1:0] a,
			input logic [31:0] wd, output logic [31:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rd = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(input logic sel, input logic [31:0] value);
		logic [dmcl_pkg::APB_ADDR_W-1:0] a;
		logic [31:0]                     rd;
		a = (sel == dmcl_pkg::REG_INDEX_BITS) ? ADDR_INDEX_BITS : ADDR_OFFSET_BITS;
		apb_access(1'b1, a, value, rd);
		if (sel == dmcl_pkg::REG_INDEX_BITS) begin
			eff_ib = (value[3:0] > LINE_BITS) ? LINE_BITS : value[3:0];
		end else begin
			eff_off = (value[3:0] < dmcl_pkg::OFFSET_MIN) ? dmcl_pkg::OFFSET_MIN :
				(value[3:0] > dmcl_pkg::OFFSET_MAX) ? dmcl_pkg::OFFSET_MAX : value[3:0];
		end
		apb_access(1'b0, a, 32'd0, rd);
		if (rd !== {28'd0, value[3:0]}) begin
			$display("%0t: register %0d readback expected %0h actual %0h",
				$time, sel, value[3:0], rd);
			mismatches++;
		end
		splits_used++;
	endtask

	// called just after the clock rises; returns just after the address is accepted
	task automatic send_addr(input logic [31:0] a);
		if ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= a;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic drain_lookups();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(0, 99) >= stall_pct);
	end

	always @(negedge clk) begin
		lookup_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat %0h", $time, m_tdata);
				mismatches++;
			end else begin
				exp_r = expected_q.pop_front();
				if (m_tdata[0] !== exp_r.hit) begin
					$display("%0t: hit expected %0d actual %0d",
						$time, exp_r.hit, m_tdata[0]);
					mismatches++;
				end
				if (m_tdata[32:1] !== exp_r.hit_count) begin
					$display("%0t: hit_count expected %0d actual %0d",
						$time, exp_r.hit_count, m_tdata[32:1]);
					mismatches++;
				end
				if (m_tdata[64:33] !== exp_r.access_count) begin
					$display("%0t: access_count expected %0d actual %0d",
						$time, exp_r.access_count, m_tdata[64:33]);
					mismatches++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_MAX) @(negedge clk);
		$display("%0t: no beat accepted for %0d cycles", $time, QUIET_MAX);
		$display("tb_top failed");
		$finish;
	end

	initial begin : stimulus
		int             plan_off [7];
		int             plan_idx [7];
		lookup_result_t pred;
		logic [31:0]    a;
		logic [31:0]    rd;
		int             pick;
		int             slot;
		int             seg;

		plan_off = '{4, 8, 15, 0, 4, 8, 3};
		plan_idx = '{10, 0, 15, 0, 1, 10, 11};
		for (int i = 0; i < LINES; i++) begin
			pred_valid[i] = 1'b0;
			pred_tag[i]   = '0;
		end
		pred_hits     = '0;
		pred_accesses = '0;
		eff_off       = 4;
		eff_ib        = 10;
		foreach (addr_pool[i]) addr_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		apb_access(1'b0, ADDR_OFFSET_BITS, 32'd0, rd);
		if (rd !== 32'd4) begin
			$display("%0t: offset_bits after reset expected 4 actual %0d", $time, rd);
			mismatches++;
		end
		apb_access(1'b0, ADDR_INDEX_BITS, 32'd0, rd);
		if (rd !== 32'd10) begin
			$display("%0t: index_bits after reset expected 10 actual %0d", $time, rd);
			mismatches++;
		end

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				drain_lookups();
				reg_write(dir_rows[r].reg_sel, dir_rows[r].data);
			end else begin
				send_addr(dir_rows[r].data);
				pred = cache_predict(dir_rows[r].data);
				expected_q.push_back(dir_rows[r].typed ? dir_rows[r].res : pred);
			end
		end

		for (int phase = 0; phase < 3; phase++) begin
			gap_pct   = (phase == 0) ? 31 : (phase == 1) ? 84 : 0;
			stall_pct = (phase == 0) ? 84 : (phase == 1) ? 31 : 0;
			for (int s = 0; s < SEGMENTS; s++) begin
				seg = phase * SEGMENTS + s;
				drain_lookups();
				reg_write(dmcl_pkg::REG_OFFSET_BITS, (seg < 7) ? plan_off[seg] :
					($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15));
				reg_write(dmcl_pkg::REG_INDEX_BITS, (seg < 7) ? plan_idx[seg] :
					($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15));
				for (int n = 0; n < SEG_ITEMS; n++) begin
					pick = $urandom_range(0, 99);
					slot = $urandom_range(0, 15);
					if (pick < 45)
						a = addr_pool[slot] ^ ($urandom & ((32'd1 << eff_off) - 1));
					else if (pick < 65)
						a = addr_pool[slot] ^ ($urandom << (eff_off + eff_ib));
					else if (pick < 80)
						a = $urandom;
					else begin
						addr_pool[slot] = $urandom;
						a = addr_pool[slot];
					end
					send_addr(a);
					expected_q.push_back(cache_predict(a));
				end
			end
		end

		drain_lookups();
		repeat (10) @(posedge clk);
		$display("Ran %0d lookups (%0d hits) over %0d register writes,", pred_accesses,
			pred_hits, splits_used);
		$display("with offset/index splits from minimum to maximum and three pacing modes.");
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/dmcl_pkg.sv
rtl/core/dmcl_ram.sv
rtl/core/dmcl_ctrl.sv
rtl/core/dmcl_dp.sv
rtl/core/direct_mapped_cache_lookup.sv
tb/sv/tb_top.sv
